[design/b64e_pkg.sv]
// Package for the streaming Base64 encoder.
// Holds the queue entry type, the pad character and the alphabet lookup.
// No dependencies.
`default_nettype none
package b64e_pkg;

   localparam logic [7:0] PAD_CHAR = 8'h3d;

   typedef struct packed {
      logic [23:0] group;
      logic [1:0]  pad_count;
      logic        fin;
   } group_type;

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      logic [7:0] c;
      c = 8'h00;
      case (v) inside
         [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
         [6'd26:6'd51]: c = 8'h61 + {2'b00, v} - 8'd26;
         [6'd52:6'd61]: c = 8'h30 + {2'b00, v} - 8'd52;
         6'd62:         c = 8'h2b;
         default:       c = 8'h2f;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

[design/b64e_if.sv]
// Valid/ready channel interfaces for the Base64 encoder.
// The request channel carries raw bytes, the response channel characters.
`default_nettype none
interface b64e_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source(output valid, output data_byte, output last_byte, input ready);
   modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last_char;
   modport source(output valid, output out_char, output last_char, input ready);
   modport sink(input valid, input out_char, input last_char, output ready);
endinterface
`default_nettype wire

[design/base64_stream_encoder_top.sv]
// Top level of the streaming Base64 encoder (standard alphabet, '=' padding).
// Instantiates b64e_front, b64e_fifo and b64e_back; uses b64e_pkg and b64e_if.
//
// One raw byte is taken per cycle while the group queue has room. Every
// third byte, or a byte flagged as the last of the message, closes a group
// that leaves as four characters, one per cycle while the output is not
// stalled; the closed group is first written into the queue, then its first
// character is loaded into the registered output. The single-character
// output sets the sustained rate: a full group of three bytes leaves as
// four characters. The queue holds QUEUE_DEPTH closed groups between halves.
`default_nettype none
module base64_stream_encoder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   b64e_req_if.sink   req_ch,
   b64e_rsp_if.source rsp_ch
);

   logic                push_valid, push_ready;
   b64e_pkg::group_type push_data;
   logic                pop_valid, pop_ready;
   b64e_pkg::group_type pop_data;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_byte    (req_ch.data_byte),
      .in_last    (req_ch.last_byte),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   b64e_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_char  (rsp_ch.out_char),
      .out_last  (rsp_ch.last_char)
   );

endmodule
`default_nettype wire

[design/b64e_front.sv]
// Front end of the Base64 encoder: collects bytes into three-byte groups.
// Pushes each closed group, with its padding count, into the group queue.
// Depends on b64e_pkg.
`default_nettype none
module b64e_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output b64e_pkg::group_type     push_data
);

   logic [1:0] fill_ff, fill_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] second_ff, second_in;
   logic       accept;

   assign in_ready = push_ready;
   assign accept   = in_valid & push_ready;

   always_comb begin
      fill_in    = fill_ff;
      first_in   = first_ff;
      second_in  = second_ff;
      push_valid = 1'b0;
      push_data  = '{group: 24'h0, pad_count: 2'd0, fin: in_last};
      case (fill_ff)
         2'd1: begin
            if (in_last) begin
               push_valid = accept;
               push_data.group = {first_ff, in_byte, 8'h00};
               push_data.pad_count = 2'd1;
               if (accept) fill_in = 2'd0;
            end else if (accept) begin
               second_in = in_byte;
               fill_in   = 2'd2;
            end
         end
         2'd2: begin
            push_valid = accept;
            push_data.group = {first_ff, second_ff, in_byte};
            push_data.pad_count = 2'd0;
            if (accept) fill_in = 2'd0;
         end
         default: begin
            if (in_last) begin
               push_valid = accept;
               push_data.group = {in_byte, 16'h0000};
               push_data.pad_count = 2'd2;
               if (accept) fill_in = 2'd0;
            end else if (accept) begin
               first_in = in_byte;
               fill_in  = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
      first_ff  <= first_in;
      second_ff <= second_in;
   end

endmodule
`default_nettype wire

[design/b64e_fifo.sv]
// Small group queue between the front and back ends of the Base64 encoder.
// Registered storage with a read and write pointer. Depends on b64e_pkg.
`default_nettype none
module b64e_fifo #(
   parameter int DEPTH = 2
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   output logic                      push_ready,
   input  wire b64e_pkg::group_type  push_data,
   output logic                      pop_valid,
   input  wire logic                 pop_ready,
   output b64e_pkg::group_type       pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

   b64e_pkg::group_type store_ff [DEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
      if (do_pop) rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      else if (!do_push && do_pop) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (do_push) store_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

[design/b64e_back.sv]
// Back end of the Base64 encoder: turns one queued group into four characters.
// Emits one character per cycle while the output is not stalled, through an output register. Depends on b64e_pkg.
`default_nettype none
module b64e_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 pop_valid,
   output logic                      pop_ready,
   input  wire b64e_pkg::group_type  pop_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [7:0]                out_char,
   output logic                      out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic [5:0] sextet;
   logic       is_pad;

   assign load      = pop_valid & (~valid_ff | out_ready);
   assign pop_ready = load & (idx_ff == 2'd3);

   always_comb begin
      case (idx_ff)
         2'd0:    sextet = pop_data.group[23:18];
         2'd1:    sextet = pop_data.group[17:12];
         2'd2:    sextet = pop_data.group[11:6];
         default: sextet = pop_data.group[5:0];
      endcase
      is_pad = ((idx_ff == 2'd3) && (pop_data.pad_count != 2'd0)) ||
               ((idx_ff == 2'd2) && (pop_data.pad_count == 2'd2));
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff & ~out_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = idx_ff + 2'd1;
         valid_in = 1'b1;
         char_in  = is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_char(sextet);
         last_in  = pop_data.fin & (idx_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule
`default_nettype wire

[design/b64e_checker.sv]
// Port-level checker for the streaming Base64 encoder and its bind statement.
// Watches only the top level's response channel signals.
`default_nettype none
module b64e_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_char,
   input wire logic       rsp_last
);

   // A stalled transaction keeps its character and flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char) && $stable(rsp_last))
      else $error("response changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char >= 8'h41 && rsp_char <= 8'h5a) ||
                    (rsp_char >= 8'h61 && rsp_char <= 8'h7a) ||
                    (rsp_char >= 8'h30 && rsp_char <= 8'h39) ||
                    rsp_char == 8'h2b || rsp_char == 8'h2f || rsp_char == 8'h3d)
      else $error("character outside the Base64 alphabet");

   // A padding character that does not end the message is followed at once by the final one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_char == 8'h3d && !rsp_last |=>
         rsp_valid && rsp_char == 8'h3d && rsp_last)
      else $error("padding not followed by the final padding character");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_char  (rsp_ch.out_char),
   .rsp_last  (rsp_ch.last_char)
);
`default_nettype wire
